[hdl/ddm_pkg.sv]
// Shared types and constants for the differential drive mixer.
// Holds the item structs, register indexes and pipeline sizing; no dependencies.
package ddm_pkg;

	localparam int unsigned Q_ONE          = 32768;
	localparam int unsigned PERCENT        = 100;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned CFG_DATA_W     = 16;
	localparam int unsigned QUO_W          = 16;
	localparam int unsigned STEPS_PER_STG  = 4;
	localparam int unsigned DIV_STAGES     = QUO_W / STEPS_PER_STG;
	localparam int unsigned NORM_STAGES    = DIV_STAGES + 1;

	// One command item
	typedef struct packed {
		logic [15:0] throttle_pulse;
		logic [15:0] steering_pulse;
		logic        host_stop;
		logic        sensor_stop;
	} cmd_t;

	// One result item
	typedef struct packed {
		logic [6:0] left_duty;
		logic       left_reverse;
		logic [6:0] right_duty;
		logic       right_reverse;
	} res_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_PULSE  = 3'd0,
		CFG_MAX_PULSE  = 3'd1,
		CFG_DEADBAND   = 3'd2,
		CFG_SPEED_GAIN = 3'd3,
		CFG_TRIM       = 3'd4
	} cfg_idx_t;

	// How a normalized value is settled at the end of the divider
	typedef enum logic [1:0] {
		NRM_DIV,
		NRM_LOW,
		NRM_HIGH,
		NRM_CENTER
	} nrm_mode_t;

endpackage

[hdl/ddm_norm.sv]
// Pulse normalizer: maps a pulse width to Q1.15 in [-1,1) through a pipelined
// restoring divider. Depends on ddm_pkg.
module ddm_norm import ddm_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        pulse,
	input  logic [15:0]        min_pulse,
	input  logic [15:0]        span,
	input  logic               span_ok,
	output logic signed [15:0] q
);

	logic [15:0]     rem_s  [DIV_STAGES+1];
	logic [QUO_W-1:0] quo_s [DIV_STAGES+1];
	nrm_mode_t       mode_s [DIV_STAGES+1];
	logic [15:0]     rem_nx [DIV_STAGES];
	logic [QUO_W-1:0] quo_nx [DIV_STAGES];
	logic [16:0]     diff;
	nrm_mode_t       mode_in;

	// Offset from the low end and range classification
	always_comb begin
		diff = {1'b0, pulse} - {1'b0, min_pulse};
		if (!span_ok) begin
			mode_in = NRM_CENTER;
		end else if (diff[16]) begin
			mode_in = NRM_LOW;
		end else if (diff[15:0] >= span) begin
			mode_in = NRM_HIGH;
		end else begin
			mode_in = NRM_DIV;
		end
	end

	// Restoring division of offset*65536 by span, four quotient bits per stage
	always_comb begin
		logic [16:0] r2;
		logic [15:0] r;
		logic [QUO_W-1:0] qv;
		for (int k = 0; k < DIV_STAGES; k++) begin
			r  = rem_s[k];
			qv = quo_s[k];
			for (int j = 0; j < STEPS_PER_STG; j++) begin
				r2 = {r, 1'b0};
				if (r2 >= {1'b0, span}) begin
					r2 = r2 - {1'b0, span};
					qv = {qv[QUO_W-2:0], 1'b1};
				end else begin
					qv = {qv[QUO_W-2:0], 1'b0};
				end
				r = r2[15:0];
			end
			rem_nx[k] = r;
			quo_nx[k] = qv;
		end
	end

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= diff[15:0];
			quo_s[0]  <= '0;
			mode_s[0] <= mode_in;
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_s[k+1]  <= rem_nx[k];
				quo_s[k+1]  <= quo_nx[k];
				mode_s[k+1] <= mode_s[k];
			end
		end
	end

	// Recenter the quotient, or saturate
	always_comb begin
		unique case (mode_s[DIV_STAGES])
			NRM_DIV:    q = signed'(quo_s[DIV_STAGES] ^ 16'h8000);
			NRM_LOW:    q = 16'sh8000;
			NRM_HIGH:   q = 16'sh7FFF;
			NRM_CENTER: q = 16'sh0000;
			default:    q = 16'sh0000;
		endcase
	end

endmodule

[hdl/differential_drive_mixer_unit.sv]
// Top level of the differential drive mixer: configuration registers, mixing
// pipeline and output skid stage. Depends on ddm_pkg and ddm_norm.
//
// Usage:
//  - Command channel (cmd, cmd_valid, cmd_stall) takes throttle and steering
//    pulse widths plus two stop flags; an item moves when valid is high and
//    stall is low.
//  - Result channel (res, res_valid, res_stall) gives per-side duty percent
//    and reverse flag, one result item per command item, in order.
//  - Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data);
//    write it only while no item is in flight. Unknown indexes are ignored.
//  - An item passes one offset stage, four divider stages of four quotient
//    bits each, deadband, gain, mix and trim stages, then the output register.
//  - Throughput is one item per cycle while cmd_stall is low; the 16-bit
//    normalizing divider is fully pipelined and each multiply stage holds two multipliers.
//  - When res_stall holds a result, one more item drops into the skid
//    register; cmd_stall rises only once that register is full, and then
//    the whole pipeline holds.
//  - Reset restores the register defaults and empties the pipeline.
module differential_drive_mixer_unit import ddm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_t                  cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [15:0]        min_pulse_q, max_pulse_q, speed_gain_q;
	logic [14:0]        deadband_q;
	logic signed [15:0] trim_q;

	logic        en;
	logic [16:0] span_w;
	logic        span_ok;
	logic signed [15:0] q_t, q_s;

	logic [NORM_STAGES:1] valid_s, stop_s;

	logic        valid_s6, stop_s6, t_neg_s6, s_neg_s6;
	logic [15:0] t_mag_s6, s_mag_s6;
	logic        valid_s7, stop_s7, t_neg_s7, s_neg_s7;
	logic [14:0] t_mag_s7, s_mag_s7;
	logic        valid_s8, stop_s8, l_neg_s8, r_neg_s8;
	logic [14:0] l_mag_s8, r_mag_s8;
	logic        valid_s9, stop_s9, l_neg_s9, r_neg_s9;
	logic [14:0] l_mag_s9, r_mag_s9;

	res_t res_q, skid_q, res_nx;
	logic res_valid_q, skid_full_q, res_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q  <= 16'd1000;
			max_pulse_q  <= 16'd2000;
			deadband_q   <= '0;
			speed_gain_q <= 16'hFFFF;
			trim_q       <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MIN_PULSE:  min_pulse_q  <= cfg_data;
				CFG_MAX_PULSE:  max_pulse_q  <= cfg_data;
				CFG_DEADBAND:   deadband_q   <= cfg_data[14:0];
				CFG_SPEED_GAIN: speed_gain_q <= cfg_data;
				CFG_TRIM:       trim_q       <= signed'(cfg_data);
				default:        ;
			endcase
		end
	end

	// Pulse range; an empty range centers both values
	assign span_w  = {1'b0, max_pulse_q} - {1'b0, min_pulse_q};
	assign span_ok = !span_w[16] && (span_w[15:0] != 16'd0);

	// Pipeline moves whenever the skid register is free
	assign en        = !skid_full_q;
	assign cmd_stall = skid_full_q;

	ddm_norm u_norm_t (
		.clk(clk), .en(en), .pulse(cmd.throttle_pulse), .min_pulse(min_pulse_q),
		.span(span_w[15:0]), .span_ok(span_ok), .q(q_t)
	);

	ddm_norm u_norm_s (
		.clk(clk), .en(en), .pulse(cmd.steering_pulse), .min_pulse(min_pulse_q),
		.span(span_w[15:0]), .span_ok(span_ok), .q(q_s)
	);

	// Valid and stop flags alongside the normalizer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[NORM_STAGES-1:1], cmd_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stop_s <= {stop_s[NORM_STAGES-1:1], cmd.host_stop | cmd.sensor_stop};
		end
	end

	// Deadband: magnitude beyond the band, sign kept only when nonzero
	logic [15:0] t_abs, s_abs;
	logic        t_over, s_over;
	always_comb begin
		t_abs  = q_t[15] ? (~q_t + 16'd1) : q_t;
		s_abs  = q_s[15] ? (~q_s + 16'd1) : q_s;
		t_over = t_abs > {1'b0, deadband_q};
		s_over = s_abs > {1'b0, deadband_q};
	end

	// Gain product, truncated toward zero
	logic [31:0] t_gain, s_gain;
	assign t_gain = 32'(t_mag_s6) * 32'(speed_gain_q);
	assign s_gain = 32'(s_mag_s6) * 32'(speed_gain_q);

	// Mix factors: steering slows the inner side
	logic [15:0] l_mix_f, r_mix_f;
	logic [30:0] l_mix, r_mix;
	always_comb begin
		l_mix_f = s_neg_s7 ? (16'h8000 - {1'b0, s_mag_s7}) : 16'h8000;
		r_mix_f = s_neg_s7 ? 16'h8000 : (16'h8000 - {1'b0, s_mag_s7});
		l_mix   = 31'(t_mag_s7) * 31'(l_mix_f);
		r_mix   = 31'(t_mag_s7) * 31'(r_mix_f);
	end

	// Trim factors: positive trim slows left, negative slows right
	logic [15:0] l_trim_f, r_trim_f;
	logic [30:0] l_trim, r_trim;
	always_comb begin
		l_trim_f = (!trim_q[15] && (trim_q != 16'sd0)) ? (16'h8000 - 16'(trim_q)) : 16'h8000;
		r_trim_f = trim_q[15] ? (16'h8000 + 16'(trim_q)) : 16'h8000;
		l_trim   = 31'(l_mag_s8) * 31'(l_trim_f);
		r_trim   = 31'(r_mag_s8) * 31'(r_trim_f);
	end

	// Stage valid bits after the normalizer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s[NORM_STAGES];
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// Stage payloads: deadband, gain, mix, trim
	always_ff @(posedge clk) begin
		if (en) begin
			stop_s6  <= stop_s[NORM_STAGES];
			t_mag_s6 <= t_over ? (t_abs - {1'b0, deadband_q}) : 16'd0;
			s_mag_s6 <= s_over ? (s_abs - {1'b0, deadband_q}) : 16'd0;
			t_neg_s6 <= q_t[15] && t_over;
			s_neg_s6 <= q_s[15] && s_over;

			stop_s7  <= stop_s6;
			t_mag_s7 <= t_gain[30:16];
			s_mag_s7 <= s_gain[30:16];
			t_neg_s7 <= t_neg_s6 && (t_gain[30:16] != 15'd0);
			s_neg_s7 <= s_neg_s6 && (s_gain[30:16] != 15'd0);

			stop_s8  <= stop_s7;
			l_mag_s8 <= l_mix[29:15];
			r_mag_s8 <= r_mix[29:15];
			l_neg_s8 <= t_neg_s7 && (l_mix[29:15] != 15'd0);
			r_neg_s8 <= t_neg_s7 && (r_mix[29:15] != 15'd0);

			stop_s9  <= stop_s8;
			l_mag_s9 <= l_trim[29:15];
			r_mag_s9 <= r_trim[29:15];
			l_neg_s9 <= l_neg_s8 && (l_trim[29:15] != 15'd0);
			r_neg_s9 <= r_neg_s8 && (r_trim[29:15] != 15'd0);
		end
	end

	// Percent of full scale, saturated
	function automatic logic [6:0] pct(input logic [14:0] m);
		logic [21:0] p;
		p = 22'(m) * 22'(PERCENT);
		return (p[21:15] > 7'(PERCENT)) ? 7'(PERCENT) : p[21:15];
	endfunction

	always_comb begin
		res_nx.left_duty     = stop_s9 ? 7'd0 : pct(l_mag_s9);
		res_nx.left_reverse  = !stop_s9 && l_neg_s9;
		res_nx.right_duty    = stop_s9 ? 7'd0 : pct(r_mag_s9);
		res_nx.right_reverse = !stop_s9 && r_neg_s9;
	end

	// Output register and skid register
	assign res_take = res_valid_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (res_take) begin
				skid_full_q <= 1'b0;
			end
		end else if (valid_s9) begin
			if (res_valid_q && !res_take) begin
				skid_full_q <= 1'b1;
			end else begin
				res_valid_q <= 1'b1;
			end
		end else if (res_take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (res_take) begin
				res_q <= skid_q;
			end
		end else if (valid_s9) begin
			if (res_valid_q && !res_take) begin
				skid_q <= res_nx;
			end else begin
				res_q <= res_nx;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A full skid register always sits behind a shown result
	assert property (@(posedge clk) disable iff (!arst_n) skid_full_q |-> res_valid_q)
		else $error("skid register full without a result on the output");

	// An arriving item that meets a held result is parked, not dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s9 && !skid_full_q && res_valid_q && res_stall) |=> skid_full_q)
		else $error("item lost while the output was stalled");

	// Duties never leave the percent range
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.left_duty <= 7'(PERCENT)) && (res_q.right_duty <= 7'(PERCENT)))
		else $error("duty above full scale");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for differential_drive_mixer_unit: predicts each result item
// from the command item and a mirror of the registers. Depends on ddm_pkg and the RTL.
module tb;
	import ddm_pkg::*;

	localparam longint UNIT        = Q_ONE;
	localparam longint PCT         = PERCENT;
	localparam int     LATENCY     = 10;
	localparam int     STALL_LIMIT = 1000;
	localparam int     LONG_HOLD   = 60;
	localparam int     N_PHASES    = 12;
	localparam int     PHASE_ITEMS = 80;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	cmd_t                  cmd = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_t                  res;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register mirror, starts at the reset values
	int pulse_lo = 1000;
	int pulse_hi = 2000;
	int band     = 0;
	int gain     = 65535;
	int trim_q   = 0;

	cmd_t cmd_pending[$];
	res_t duty_expect[$];
	res_t want;
	int   items_queued = 0;
	int   results_seen = 0;
	int   err_count = 0;
	int   quiet_cycles = 0;
	logic cmd_taken = 1'b0;
	logic res_taken = 1'b0;
	logic cmd_gaps = 1'b0;
	logic res_gaps = 1'b0;
	logic cmd_armed = 1'b0;
	int   cmd_gap = 0;
	int   res_wait = 0;
	int   res_hold = 0;
	int   hold_asks = 0;
	int   hold_seen = 0;

	differential_drive_mixer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Sign-magnitude product, truncated toward zero
	function automatic longint sm_scale(longint a, longint b, int sh);
		longint m, r;
		m = (a < 0) ? -a : a;
		r = (m * b) >>> sh;
		return (a < 0) ? -r : r;
	endfunction

	// Map a pulse width to Q1.15, then apply deadband and gain
	function automatic longint shaped_unit(logic [15:0] x);
		longint span, q, xv;
		xv = x;
		span = longint'(pulse_hi) - longint'(pulse_lo);
		if (span <= 0) begin
			q = 0;
		end else begin
			q = ((xv - pulse_lo) * 2 * UNIT) / span - UNIT;
			if (q > UNIT - 1) q = UNIT - 1;
			if (q < -UNIT) q = -UNIT;
		end
		if (q > band) q = q - band;
		else if (q < -band) q = q + band;
		else q = 0;
		return sm_scale(q, gain, 16);
	endfunction

	function automatic logic [6:0] to_percent(longint d);
		longint p;
		p = (((d < 0) ? -d : d) * PCT) >>> 15;
		if (p > PCT) p = PCT;
		return p[6:0];
	endfunction

	// Expected duties and directions for one command item
	function automatic res_t mix_duty(cmd_t c);
		longint t, s, left, right;
		res_t r;
		t = shaped_unit(c.throttle_pulse);
		s = shaped_unit(c.steering_pulse);
		left = 0;
		right = 0;
		if (!(c.host_stop || c.sensor_stop)) begin
			left = t;
			right = t;
			if (s < 0) left = sm_scale(t, UNIT + s, 15);
			else if (s > 0) right = sm_scale(t, UNIT - s, 15);
			if (trim_q > 0) left = sm_scale(left, UNIT - trim_q, 15);
			else if (trim_q < 0) right = sm_scale(right, UNIT + trim_q, 15);
		end
		r.left_duty = to_percent(left);
		r.left_reverse = (left < 0);
		r.right_duty = to_percent(right);
		r.right_reverse = (right < 0);
		return r;
	endfunction

	// Mostly within the configured pulse range plus a margin, else any width
	function automatic logic [15:0] draw_pulse();
		int lo, hi, margin;
		if ($urandom_range(0, 3) == 0 || pulse_hi <= pulse_lo) return 16'($urandom);
		margin = (pulse_hi - pulse_lo) / 8;
		lo = pulse_lo - margin;
		if (lo < 0) lo = 0;
		hi = pulse_hi + margin;
		if (hi > 65535) hi = 65535;
		return 16'($urandom_range(hi, lo));
	endfunction

	task automatic flag_mismatch(string msg);
		err_count++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_MIN_PULSE:  pulse_lo = data;
			CFG_MAX_PULSE:  pulse_hi = data;
			CFG_DEADBAND:   band = data[14:0];
			CFG_SPEED_GAIN: gain = data;
			CFG_TRIM:       trim_q = $signed(data);
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [15:0] lo, logic [15:0] hi, logic [15:0] db,
			logic [15:0] g, logic [15:0] tr);
		write_reg(CFG_MIN_PULSE, lo);
		write_reg(CFG_MAX_PULSE, hi);
		write_reg(CFG_DEADBAND, db);
		write_reg(CFG_SPEED_GAIN, g);
		write_reg(CFG_TRIM, tr);
		// unknown index must leave every register alone
		write_reg(CFG_NONE, 16'($urandom));
	endtask

	task automatic send(logic [15:0] th, logic [15:0] st, logic hs, logic ss);
		cmd_t c;
		c.throttle_pulse = th;
		c.steering_pulse = st;
		c.host_stop = hs;
		c.sensor_stop = ss;
		cmd_pending.push_back(c);
		items_queued++;
	endtask

	task automatic wait_drain();
		while (results_seen != items_queued) @(negedge clk);
	endtask

	// Stimulus and phase sequencing
	initial begin
		int p, k;
		logic [15:0] lo, hi, tmp;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at reset settings
		send(16'd1500, 16'd1500, 1'b0, 1'b0);
		send(16'd2000, 16'd1500, 1'b0, 1'b0);
		send(16'd1000, 16'd1500, 1'b0, 1'b0);
		send(16'd0, 16'd1500, 1'b0, 1'b0);
		send(16'hFFFF, 16'd1500, 1'b0, 1'b0);
		send(16'd2000, 16'd2000, 1'b0, 1'b0);
		send(16'd2000, 16'd1000, 1'b0, 1'b0);
		send(16'd1000, 16'd2000, 1'b0, 1'b0);
		send(16'd1499, 16'd1500, 1'b0, 1'b0);
		send(16'd1500, 16'd1499, 1'b0, 1'b0);
		send(16'd2000, 16'd1750, 1'b0, 1'b0);
		send(16'd1250, 16'd1250, 1'b0, 1'b0);
		send(16'd2000, 16'd1500, 1'b1, 1'b0);
		send(16'd2000, 16'd1500, 1'b0, 1'b1);
		send(16'd1000, 16'd1000, 1'b1, 1'b1);
		send(16'hFFFF, 16'd0, 1'b0, 1'b0);
		send(16'd0, 16'hFFFF, 1'b0, 1'b0);
		send(16'hAAAA, 16'h5555, 1'b0, 1'b0);
		wait_drain();

		// empty pulse range: equal and inverted bounds
		set_regs(16'd1500, 16'd1500, 16'd0, 16'hFFFF, 16'd0);
		send(16'd0, 16'hFFFF, 1'b0, 1'b0);
		send(16'd1500, 16'd2000, 1'b0, 1'b0);
		wait_drain();
		set_regs(16'd2000, 16'd1000, 16'd0, 16'hFFFF, 16'd0);
		send(16'hFFFF, 16'd0, 1'b0, 1'b0);
		send(16'd1200, 16'd1800, 1'b0, 1'b0);
		wait_drain();

		for (p = 0; p < N_PHASES; p++) begin
			case (p)
				0: set_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'h7FFF);
				1: set_regs(16'd1000, 16'd2000, 16'h7FFF, 16'd0, 16'h8000);
				2: set_regs(16'd1000, 16'd2000, 16'd200, 16'hFFFF, 16'd1);
				3: set_regs(16'hFFFF, 16'd0, 16'd100, 16'd40000, 16'd0);
				4: set_regs(16'd0, 16'd1, 16'd0, 16'd50000, 16'hFFFF);
				default: begin
					lo = 16'($urandom_range(0, 4000));
					hi = 16'(lo + $urandom_range(1, 4000));
					if ($urandom_range(0, 7) == 0) begin
						tmp = lo;
						lo = hi;
						hi = tmp;
					end
					set_regs(lo, hi,
						($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 6000)),
						16'($urandom_range(20000, 65535)),
						($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 16000) - 8000));
				end
			endcase
			cmd_gaps = (p == 0 || p == 2) ? 1'b0 : 1'($urandom_range(0, 1));
			res_gaps = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
			@(posedge clk);
			// receiver holds off while the sender keeps offering
			if (p == 2) hold_asks++;
			for (k = 0; k < PHASE_ITEMS; k++)
				send(draw_pulse(), draw_pulse(), ($urandom_range(0, 9) == 0),
					($urandom_range(0, 9) == 0));
			wait_drain();
		end

		repeat (LATENCY + 2) @(posedge clk);
		if (err_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	// Driver: present queued items at the falling edge, with random gaps when cmd_gaps is set
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_taken)) begin
			if (!cmd_armed && cmd_pending.size() > 0) begin
				cmd_armed = 1'b1;
				cmd_gap = cmd_gaps ? $urandom_range(0, 9) : 0;
			end
			if (cmd_armed && cmd_gap == 0) begin
				cmd <= cmd_pending.pop_front();
				cmd_valid <= 1'b1;
				cmd_armed = 1'b0;
			end else begin
				if (cmd_armed) cmd_gap--;
				cmd_valid <= 1'b0;
			end
		end
	end

	// Receiver: when res_gaps is set, stall after each item, and hold off for a long stretch on request
	always @(negedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			res_hold = LONG_HOLD;
		end
		if (res_taken) res_wait = res_gaps ? $urandom_range(0, 9) : 0;
		if (res_hold > 0) begin
			res_hold--;
			res_stall <= 1'b1;
		end else if (res_wait > 0) begin
			res_wait--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Monitor: predict on accepted commands, check accepted results, watch for hangs
	always @(posedge clk) begin
		cmd_taken <= arst_n && cmd_valid && !cmd_stall;
		res_taken <= arst_n && res_valid && !res_stall;
		if (arst_n && cmd_valid && !cmd_stall) duty_expect.push_back(mix_duty(cmd));
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (duty_expect.size() == 0) begin
				flag_mismatch("result item with nothing expected");
			end else begin
				want = duty_expect.pop_front();
				if (res.left_duty !== want.left_duty || res.left_reverse !== want.left_reverse
						|| res.right_duty !== want.right_duty
						|| res.right_reverse !== want.right_reverse)
					flag_mismatch($sformatf(
						"result %0d got L %0d/%0b R %0d/%0b, want L %0d/%0b R %0d/%0b",
						results_seen, res.left_duty, res.left_reverse, res.right_duty,
						res.right_reverse, want.left_duty, want.left_reverse,
						want.right_duty, want.right_reverse));
			end
		end
		// count only cycles where work is outstanding and nothing moves
		if (results_seen != items_queued && !(cmd_valid && !cmd_stall)
				&& !(res_valid && !res_stall))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no progress for %0d cycles", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

endmodule

[filelist.f]
hdl/ddm_pkg.sv
hdl/ddm_norm.sv
hdl/differential_drive_mixer_unit.sv
dv/tb.sv
